/* src/tilt_gesture_turn_signal_detector_defines.svh */
// Assertion macros for the tilt gesture turn signal detector
`ifndef TILT_GESTURE_TURN_SIGNAL_DETECTOR_DEFINES_SVH
`define TILT_GESTURE_TURN_SIGNAL_DETECTOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TGD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgd check failed");

// next-cycle implication, checked out of reset
`define TGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgd check failed");

`endif

/* src/tgd_pkg.sv */
package tgd_pkg;

    localparam int BASE_FRAC_BITS = 16;
    localparam int ANGLE_W        = 16;
    localparam int MARGIN_W       = 15;
    localparam int ALPHA_W        = 16;
    localparam int BL_W           = ANGLE_W + BASE_FRAC_BITS;
    localparam int CMP_W          = BL_W + 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_BAND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAISE_MARGIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_MARGIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_ALPHA = 2'd3;

    localparam logic [MARGIN_W-1:0] NEUTRAL_BAND_RST    = 15'd2000;
    localparam logic [MARGIN_W-1:0] RAISE_MARGIN_RST    = 15'd3000;
    localparam logic [MARGIN_W-1:0] WIDE_MARGIN_RST     = 15'd4000;
    localparam logic [ALPHA_W-1:0]  SMOOTHING_ALPHA_RST = 16'd655;

    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_LEFT_ON   = 3'd1;
    localparam logic [2:0] CMD_LEFT_OFF  = 3'd2;
    localparam logic [2:0] CMD_RIGHT_ON  = 3'd3;
    localparam logic [2:0] CMD_RIGHT_OFF = 3'd4;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } sample_t;

    typedef struct packed {
        logic [2:0] command;
        logic       is_neutral;
        logic       left_signal;
        logic       right_signal;
    } result_t;

    typedef struct packed {
        logic neutral;
        logic raised;
        logic wide;
    } class_t;

    function automatic logic signed [BL_W-1:0] scale_angle(input logic signed [ANGLE_W-1:0] a);
        return $signed({a, {BASE_FRAC_BITS{1'b0}}});
    endfunction

    function automatic logic signed [CMP_W-1:0] scale_margin(input logic [MARGIN_W-1:0] m);
        return $signed({{(CMP_W - MARGIN_W - BASE_FRAC_BITS){1'b0}}, m,
                        {BASE_FRAC_BITS{1'b0}}});
    endfunction

endpackage

/* src/tgd_smooth.sv */
module tgd_smooth (
    input  logic signed [tgd_pkg::BL_W-1:0]    base,
    input  logic signed [tgd_pkg::ANGLE_W-1:0] angle,
    input  logic        [tgd_pkg::ALPHA_W-1:0] alpha,
    output logic signed [tgd_pkg::BL_W-1:0]    smoothed
);
    import tgd_pkg::*;

    localparam int DIFF_W = BL_W + 1;
    localparam int PROD_W = DIFF_W + ALPHA_W + 1;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rounded;
    logic signed [PROD_W-1:0] step;

    assign diff     = DIFF_W'(scale_angle(angle)) - DIFF_W'(base);
    assign prod     = PROD_W'(diff) * PROD_W'($signed({1'b0, alpha}));
    assign rounded  = prod + PROD_W'(1 << (ALPHA_W - 1));
    assign step     = rounded >>> ALPHA_W;
    assign smoothed = base + BL_W'(step);

endmodule

/* src/tgd_classify.sv */
module tgd_classify (
    input  logic signed [tgd_pkg::ANGLE_W-1:0]  pitch_angle,
    input  logic signed [tgd_pkg::ANGLE_W-1:0]  yaw_angle,
    input  logic signed [tgd_pkg::BL_W-1:0]     pitch_base,
    input  logic signed [tgd_pkg::BL_W-1:0]     yaw_base,
    input  logic        [tgd_pkg::MARGIN_W-1:0] neutral_band,
    input  logic        [tgd_pkg::MARGIN_W-1:0] raise_margin,
    input  logic        [tgd_pkg::MARGIN_W-1:0] wide_margin,
    output tgd_pkg::class_t                     cls
);
    import tgd_pkg::*;

    logic signed [CMP_W-1:0] p;
    logic signed [CMP_W-1:0] y;
    logic signed [CMP_W-1:0] pb;
    logic signed [CMP_W-1:0] yb;
    logic signed [CMP_W-1:0] band;

    assign p    = CMP_W'(scale_angle(pitch_angle));
    assign y    = CMP_W'(scale_angle(yaw_angle));
    assign pb   = CMP_W'(pitch_base);
    assign yb   = CMP_W'(yaw_base);
    assign band = scale_margin(neutral_band);

    assign cls.neutral = (p < pb + band) && (p >= pb - band) &&
                         (y > yb - band) && (y <= yb + band);
    assign cls.raised  = p > pb + scale_margin(raise_margin);
    assign cls.wide    = y < yb - scale_margin(wide_margin);

endmodule

/* src/tilt_gesture_turn_signal_detector.sv */
// Channel   Direction  Handshake                 Payload
// sample    in         sample_valid/sample_stall tgd_pkg::sample_t (pitch, yaw)
// result    out        result_valid/result_stall tgd_pkg::result_t (command, flags)
// cfg       in         cfg_we                    cfg_index, cfg_data
//
// One item per cycle sustained while result_stall is low; each accepted item
// passes through the input register, then the result register, to result_valid.
// The baseline smoothing, classification and signal update sit between those
// two registers; the baselines and flags close their loop through a single register.
// rst_n sets valid bits, baselines, flags and config registers to reset values.
// A stalled result holds; one further item waits in the input register.
`include "tilt_gesture_turn_signal_detector_defines.svh"

module tilt_gesture_turn_signal_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  tgd_pkg::sample_t                    sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output tgd_pkg::result_t                    result,
    input  logic                                cfg_we,
    input  logic [tgd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tgd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tgd_pkg::*;

    logic [MARGIN_W-1:0] neutral_band_reg;
    logic [MARGIN_W-1:0] raise_margin_reg;
    logic [MARGIN_W-1:0] wide_margin_reg;
    logic [ALPHA_W-1:0]  smoothing_alpha_reg;

    sample_t s1_reg;
    logic    s1_valid_reg;
    logic    s1_valid_next;

    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    logic    result_valid_next;

    logic                   baseline_valid_reg;
    logic signed [BL_W-1:0] pitch_baseline_reg;
    logic signed [BL_W-1:0] pitch_baseline_next;
    logic signed [BL_W-1:0] yaw_baseline_reg;
    logic signed [BL_W-1:0] yaw_baseline_next;
    logic                   raised_flag_reg;
    logic                   wide_flag_reg;
    logic                   left_active_reg;
    logic                   left_active_next;
    logic                   right_active_reg;
    logic                   right_active_next;

    logic signed [BL_W-1:0] pitch_smoothed;
    logic signed [BL_W-1:0] yaw_smoothed;
    class_t                 cls;
    logic                   out_free;
    logic                   advance;
    logic                   sample_take;

    assign out_free     = !result_valid_reg || !result_stall;
    assign advance      = s1_valid_reg && out_free;
    assign sample_stall = s1_valid_reg && !out_free;
    assign sample_take  = sample_valid && !sample_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    tgd_smooth u_pitch_smooth (
        .base     (pitch_baseline_reg),
        .angle    (s1_reg.pitch_angle),
        .alpha    (smoothing_alpha_reg),
        .smoothed (pitch_smoothed)
    );

    tgd_smooth u_yaw_smooth (
        .base     (yaw_baseline_reg),
        .angle    (s1_reg.yaw_angle),
        .alpha    (smoothing_alpha_reg),
        .smoothed (yaw_smoothed)
    );

    always_comb
    begin
        if (!baseline_valid_reg)
        begin
            pitch_baseline_next = scale_angle(s1_reg.pitch_angle);
            yaw_baseline_next   = scale_angle(s1_reg.yaw_angle);
        end
        else if (!wide_flag_reg && !raised_flag_reg)
        begin
            pitch_baseline_next = pitch_smoothed;
            yaw_baseline_next   = yaw_smoothed;
        end
        else
        begin
            pitch_baseline_next = pitch_baseline_reg;
            yaw_baseline_next   = yaw_baseline_reg;
        end
    end

    tgd_classify u_classify (
        .pitch_angle  (s1_reg.pitch_angle),
        .yaw_angle    (s1_reg.yaw_angle),
        .pitch_base   (pitch_baseline_next),
        .yaw_base     (yaw_baseline_next),
        .neutral_band (neutral_band_reg),
        .raise_margin (raise_margin_reg),
        .wide_margin  (wide_margin_reg),
        .cls          (cls)
    );

    always_comb
    begin
        left_active_next    = left_active_reg;
        right_active_next   = right_active_reg;
        result_next.command = CMD_NONE;
        if (right_active_reg && cls.neutral)
        begin
            result_next.command = CMD_RIGHT_OFF;
            right_active_next   = 1'b0;
        end
        else if (left_active_reg && cls.neutral)
        begin
            result_next.command = CMD_LEFT_OFF;
            left_active_next    = 1'b0;
        end
        else if (!right_active_reg && !left_active_reg && cls.raised)
        begin
            result_next.command = CMD_RIGHT_ON;
            right_active_next   = 1'b1;
        end
        else if (!right_active_reg && !left_active_reg && cls.wide)
        begin
            result_next.command = CMD_LEFT_ON;
            left_active_next    = 1'b1;
        end
        result_next.is_neutral   = cls.neutral;
        result_next.left_signal  = left_active_next;
        result_next.right_signal = right_active_next;
    end

    always_comb
    begin
        if (sample_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        result_valid_next = out_free ? s1_valid_reg : result_valid_reg;
    end

    // control, configuration and gesture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neutral_band_reg    <= NEUTRAL_BAND_RST;
            raise_margin_reg    <= RAISE_MARGIN_RST;
            wide_margin_reg     <= WIDE_MARGIN_RST;
            smoothing_alpha_reg <= SMOOTHING_ALPHA_RST;
            s1_valid_reg        <= 1'b0;
            result_valid_reg    <= 1'b0;
            baseline_valid_reg  <= 1'b0;
            pitch_baseline_reg  <= '0;
            yaw_baseline_reg    <= '0;
            raised_flag_reg     <= 1'b0;
            wide_flag_reg       <= 1'b0;
            left_active_reg     <= 1'b0;
            right_active_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NEUTRAL_BAND:    neutral_band_reg    <= cfg_data[MARGIN_W-1:0];
                    REG_RAISE_MARGIN:    raise_margin_reg    <= cfg_data[MARGIN_W-1:0];
                    REG_WIDE_MARGIN:     wide_margin_reg     <= cfg_data[MARGIN_W-1:0];
                    REG_SMOOTHING_ALPHA: smoothing_alpha_reg <= cfg_data[ALPHA_W-1:0];
                    default:             ;
                endcase
            end
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (advance)
            begin
                baseline_valid_reg <= 1'b1;
                pitch_baseline_reg <= pitch_baseline_next;
                yaw_baseline_reg   <= yaw_baseline_next;
                raised_flag_reg    <= cls.raised;
                wide_flag_reg      <= cls.wide;
                left_active_reg    <= left_active_next;
                right_active_reg   <= right_active_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            s1_reg <= sample;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    `TGD_ASSERT_NOW(a_one_side_active, left_active_reg, !right_active_reg)
    `TGD_ASSERT_NEXT(a_baseline_kept, baseline_valid_reg, baseline_valid_reg)
    `TGD_ASSERT_NOW(a_stall_only_when_full, sample_stall, s1_valid_reg && result_valid_reg)
    `TGD_ASSERT_NOW(a_right_on_sets, result_valid && (result.command == CMD_RIGHT_ON), result.right_signal && !result.left_signal)

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import tgd_pkg::*;

    localparam int CYCLE_LIMIT       = 500000;
    localparam int PLAN_ROWS         = 25;
    localparam int FIRST_EDGE_ROW    = 1;
    localparam int FIRST_EXTREME_ROW = 17;
    localparam int PRESET_PHASES     = 5;
    localparam int RANDOM_PHASES     = 3;
    localparam int ITEMS_PER_PHASE   = 105;
    localparam int SETTLE_CYCLES     = 4;

    typedef enum int {
        POSE_NEAR,
        POSE_RAISE,
        POSE_WIDE,
        POSE_BOTH,
        POSE_EDGE,
        POSE_NOISE
    } pose_e;

    typedef struct packed {
        sample_t s;
        logic    typed;
        result_t want;
    } plan_row_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] band;
        logic [CFG_DATA_W-1:0] raise;
        logic [CFG_DATA_W-1:0] wide;
        logic [CFG_DATA_W-1:0] alpha;
    } settings_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    sample_t               sample = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_NEUTRAL_BAND;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [MARGIN_W-1:0] band_cfg  = NEUTRAL_BAND_RST;
    logic [MARGIN_W-1:0] raise_cfg = RAISE_MARGIN_RST;
    logic [MARGIN_W-1:0] wide_cfg  = WIDE_MARGIN_RST;
    logic [ALPHA_W-1:0]  alpha_cfg = SMOOTHING_ALPHA_RST;

    bit     have_base = 1'b0;
    longint pitch_base = 0;
    longint yaw_base = 0;
    bit     raised_seen = 1'b0;
    bit     wide_seen = 1'b0;
    bit     left_lit = 1'b0;
    bit     right_lit = 1'b0;

    result_t predicted_outcomes[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      samples_sent = 0;
    int      stall_left = 0;
    int      cycles = 0;
    bit      tx_calm = 1'b0;
    bit      rx_calm = 1'b0;

    plan_row_t plan [PLAN_ROWS] = '{
        '{'{16'sd0, 16'sd0}, 1'b1, '{CMD_NONE, 1'b1, 1'b0, 1'b0}},
        '{'{16'sd999, 16'sd0}, 1'b1, '{CMD_NONE, 1'b1, 1'b0, 1'b0}},
        '{'{16'sd1000, 16'sd0}, 1'b1, '{CMD_NONE, 1'b0, 1'b0, 1'b0}},
        '{'{-16'sd1000, 16'sd0}, 1'b1, '{CMD_NONE, 1'b1, 1'b0, 1'b0}},
        '{'{-16'sd1001, 16'sd0}, 1'b1, '{CMD_NONE, 1'b0, 1'b0, 1'b0}},
        '{'{16'sd0, 16'sd1000}, 1'b1, '{CMD_NONE, 1'b1, 1'b0, 1'b0}},
        '{'{16'sd0, 16'sd1001}, 1'b1, '{CMD_NONE, 1'b0, 1'b0, 1'b0}},
        '{'{16'sd0, -16'sd1000}, 1'b1, '{CMD_NONE, 1'b0, 1'b0, 1'b0}},
        '{'{16'sd0, -16'sd999}, 1'b1, '{CMD_NONE, 1'b1, 1'b0, 1'b0}},
        '{'{16'sd1001, 16'sd0}, 1'b1, '{CMD_RIGHT_ON, 1'b0, 1'b0, 1'b1}},
        '{'{16'sd999, 16'sd0}, 1'b1, '{CMD_RIGHT_OFF, 1'b1, 1'b0, 1'b0}},
        '{'{16'sd0, -16'sd1001}, 1'b1, '{CMD_LEFT_ON, 1'b0, 1'b1, 1'b0}},
        '{'{16'sd1001, 16'sd0}, 1'b1, '{CMD_NONE, 1'b0, 1'b1, 1'b0}},
        '{'{-16'sd1000, 16'sd1000}, 1'b1, '{CMD_LEFT_OFF, 1'b1, 1'b0, 1'b0}},
        '{'{16'sd1001, -16'sd1001}, 1'b1, '{CMD_RIGHT_ON, 1'b0, 1'b0, 1'b1}},
        '{'{16'sd0, -16'sd1001}, 1'b1, '{CMD_NONE, 1'b0, 1'b0, 1'b1}},
        '{'{16'sd0, 16'sd0}, 1'b1, '{CMD_RIGHT_OFF, 1'b1, 1'b0, 1'b0}},
        '{'{16'sh7FFF, 16'sh7FFF}, 1'b0, '0},
        '{'{16'sh8000, 16'sh8000}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh8000}, 1'b0, '0},
        '{'{16'sh8000, 16'sh7FFF}, 1'b0, '0},
        '{'{16'sd18000, -16'sd18000}, 1'b0, '0},
        '{'{-16'sd18000, 16'sd18000}, 1'b0, '0},
        '{'{16'sd0, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, 16'sd0}, 1'b0, '0}
    };

    settings_t presets [PRESET_PHASES] = '{
        '{16'd2000, 16'd3000, 16'd4000, 16'd655},
        '{16'd0, 16'd0, 16'd0, 16'hFFFF},
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1},
        '{16'h85DC, 16'h89C4, 16'h8BB8, 16'd0},
        '{16'd18000, 16'd18000, 16'd18000, 16'h8000}
    };

    tilt_gesture_turn_signal_detector uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint ease_toward(input longint base, input longint target);
        longint step;
        step = (target - base) * longint'(alpha_cfg);
        return base + ((step + 32768) >>> 16);
    endfunction

    function automatic result_t predict_outcome(input sample_t s);
        longint  p;
        longint  y;
        longint  band;
        longint  rmar;
        longint  wmar;
        bit      neutral;
        result_t r;
        p    = longint'($signed(s.pitch_angle)) <<< BASE_FRAC_BITS;
        y    = longint'($signed(s.yaw_angle)) <<< BASE_FRAC_BITS;
        band = longint'(band_cfg) <<< BASE_FRAC_BITS;
        rmar = longint'(raise_cfg) <<< BASE_FRAC_BITS;
        wmar = longint'(wide_cfg) <<< BASE_FRAC_BITS;
        if (!have_base)
        begin
            pitch_base = p;
            yaw_base   = y;
            have_base  = 1'b1;
        end
        else if (!wide_seen && !raised_seen)
        begin
            pitch_base = ease_toward(pitch_base, p);
            yaw_base   = ease_toward(yaw_base, y);
        end
        neutral = (p < pitch_base + band) && (p >= pitch_base - band) &&
                  (y > yaw_base - band) && (y <= yaw_base + band);
        raised_seen = p > pitch_base + rmar;
        wide_seen   = y < yaw_base - wmar;
        r.command = CMD_NONE;
        if (right_lit && neutral)
        begin
            r.command = CMD_RIGHT_OFF;
            right_lit = 1'b0;
        end
        else if (left_lit && neutral)
        begin
            r.command = CMD_LEFT_OFF;
            left_lit  = 1'b0;
        end
        else if (!right_lit && !left_lit && raised_seen)
        begin
            r.command = CMD_RIGHT_ON;
            right_lit = 1'b1;
        end
        else if (!left_lit && !right_lit && wide_seen)
        begin
            r.command = CMD_LEFT_ON;
            left_lit  = 1'b1;
        end
        r.is_neutral   = neutral;
        r.left_signal  = left_lit;
        r.right_signal = right_lit;
        return r;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] to_angle(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[ANGLE_W-1:0];
    endfunction

    function automatic longint jitter(input longint spread);
        return longint'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // aim each pose but noise at the baselines so gestures land near thresholds
    function automatic sample_t pose_sample(input pose_e pose);
        longint  pb;
        longint  yb;
        longint  p;
        longint  y;
        longint  spread;
        sample_t s;
        pb     = pitch_base >>> BASE_FRAC_BITS;
        yb     = yaw_base >>> BASE_FRAC_BITS;
        spread = longint'(band_cfg) + 20;
        p      = pb + jitter(spread);
        y      = yb + jitter(spread);
        case (pose)
            POSE_RAISE:
                p = pb + longint'(raise_cfg) + longint'($urandom_range(1, 2500));
            POSE_WIDE:
                y = yb - longint'(wide_cfg) - longint'($urandom_range(1, 2500));
            POSE_BOTH:
            begin
                p = pb + longint'(raise_cfg) + longint'($urandom_range(1, 2500));
                y = yb - longint'(wide_cfg) - longint'($urandom_range(1, 2500));
            end
            POSE_EDGE:
            begin
                case ($urandom_range(0, 2))
                    0: p = pb + longint'(band_cfg);
                    1: p = pb - longint'(band_cfg);
                    default: p = pb + longint'(raise_cfg);
                endcase
                case ($urandom_range(0, 2))
                    0: y = yb + longint'(band_cfg);
                    1: y = yb - longint'(band_cfg);
                    default: y = yb - longint'(wide_cfg);
                endcase
                p = p + longint'($urandom_range(0, 2)) - 1;
                y = y + longint'($urandom_range(0, 2)) - 1;
            end
            default:
            begin
            end
        endcase
        s.pitch_angle = to_angle(p);
        s.yaw_angle   = to_angle(y);
        if (pose == POSE_NOISE)
            s = sample_t'($urandom);
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch on result %0d: %0s got %0d, want %0d",
                 results_seen, what, got, want);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (predicted_outcomes.size() == 0)
            report_mismatch("unrequested item, command", got.command, -1);
        else
        begin
            want = predicted_outcomes.pop_front();
            if (got.command !== want.command)
                report_mismatch("command", got.command, want.command);
            if (got.is_neutral !== want.is_neutral)
                report_mismatch("is_neutral", got.is_neutral, want.is_neutral);
            if (got.left_signal !== want.left_signal)
                report_mismatch("left_signal", got.left_signal, want.left_signal);
            if (got.right_signal !== want.right_signal)
                report_mismatch("right_signal", got.right_signal, want.right_signal);
        end
        results_seen++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                check_result(result);
                if ($urandom_range(0, 31) == 0)
                    rx_calm = !rx_calm;
                stall_left = rx_calm ? 0 : $urandom_range(0, 15);
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // valid stays high across back-to-back items; it drops only for a gap
    task automatic send_sample(input sample_t s, input logic typed, input result_t typed_want);
        int      gap;
        result_t want;
        if ($urandom_range(0, 31) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample       <= s;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
        want = predict_outcome(s);
        if (typed)
            want = typed_want;
        predicted_outcomes.push_back(want);
        samples_sent++;
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        while (predicted_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_NEUTRAL_BAND: band_cfg = val[MARGIN_W-1:0];
            REG_RAISE_MARGIN: raise_cfg = val[MARGIN_W-1:0];
            REG_WIDE_MARGIN: wide_cfg = val[MARGIN_W-1:0];
            REG_SMOOTHING_ALPHA: alpha_cfg = val[ALPHA_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic load_settings(input settings_t cfg);
        write_reg(REG_NEUTRAL_BAND, cfg.band);
        write_reg(REG_RAISE_MARGIN, cfg.raise);
        write_reg(REG_WIDE_MARGIN, cfg.wide);
        write_reg(REG_SMOOTHING_ALPHA, cfg.alpha);
        cfg_we <= 1'b0;
    endtask

    // rest, hold a raise, wide, both or edge pose, then rest; or one noise sample
    task automatic run_gesture();
        int    pick;
        pose_e pose;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            send_sample(pose_sample(POSE_NOISE), 1'b0, '0);
        else
        begin
            if (pick < 5)
                pose = POSE_RAISE;
            else if (pick < 8)
                pose = POSE_WIDE;
            else if (pick == 8)
                pose = POSE_BOTH;
            else
                pose = POSE_EDGE;
            repeat ($urandom_range(1, 3)) send_sample(pose_sample(POSE_NEAR), 1'b0, '0);
            repeat ($urandom_range(1, 4)) send_sample(pose_sample(pose), 1'b0, '0);
            repeat ($urandom_range(1, 3)) send_sample(pose_sample(POSE_NEAR), 1'b0, '0);
        end
    endtask

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int        goal;
        settings_t cfg;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (r == FIRST_EDGE_ROW)
            begin
                settle();
                load_settings('{16'd1000, 16'd1000, 16'd1000, 16'd0});
            end
            if (r == FIRST_EXTREME_ROW)
            begin
                settle();
                load_settings('{16'd2000, 16'd3000, 16'd4000, 16'd655});
            end
            send_sample(plan[r].s, plan[r].typed, plan[r].want);
        end
        for (int ph = 0; ph < PRESET_PHASES + RANDOM_PHASES; ph++)
        begin
            settle();
            if (ph < PRESET_PHASES)
                cfg = presets[ph];
            else
            begin
                cfg.band  = $urandom_range(0, 8000);
                cfg.raise = $urandom_range(0, 9000);
                cfg.wide  = $urandom_range(0, 9000);
                cfg.alpha = $urandom_range(0, 65535);
            end
            load_settings(cfg);
            goal = samples_sent + ITEMS_PER_PHASE;
            while (samples_sent < goal)
                run_gesture();
        end
        settle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/tgd_pkg.sv
src/tgd_smooth.sv
src/tgd_classify.sv
src/tilt_gesture_turn_signal_detector.sv
bench/testbench.sv
